FILE: sv/sfmd_pkg.sv
// ----------------------------------------------------------------------------
// sfmd_pkg
// Shared types, constants and channel layout helpers for the frame decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package sfmd_pkg;

    // frame header codes
    localparam logic [7:0] HDR_RC  = 8'h0F;
    localparam logic [7:0] HDR_EXT = 8'hFF;

    // configuration register indexes
    localparam logic [1:0] CFG_GAIN_FIRST    = 2'd0;
    localparam logic [1:0] CFG_OFFSET_FIRST  = 2'd1;
    localparam logic [1:0] CFG_GAIN_SECOND   = 2'd2;
    localparam logic [1:0] CFG_OFFSET_SECOND = 2'd3;

    localparam logic signed [31:0] GAIN_RESET   = 32'sd65536;
    localparam logic signed [31:0] OFFSET_RESET = 32'sd0;

    // mode values
    localparam logic [5:0] MODE_ZERO  = 6'd0;
    localparam logic [5:0] MODE_DRIVE = 6'd1;
    localparam logic [5:0] MODE_FIXED = 6'd2;
    localparam logic [5:0] MODE_THREE = 6'd3;
    localparam logic [5:0] MODE_FIVE  = 6'd5;
    localparam logic [5:0] MODE_HIGH  = 6'd32;

    // channel command levels and fixed thrust
    localparam logic signed [15:0] CMD_HI       = 16'sd100;
    localparam logic signed [15:0] CMD_LO       = -16'sd100;
    localparam logic signed [15:0] CMD_ZERO     = 16'sd0;
    localparam logic signed [15:0] THRUST_FIXED = -16'sd30;
    localparam logic signed [15:0] THRUST_MIN   = -16'sd32768;
    localparam logic signed [15:0] THRUST_MAX   = 16'sd32767;

    // channel slots: ch1, ch2, ch4, ch5, ch6, ch7
    localparam int NUM_SLOTS = 6;
    localparam logic [2:0] LAST_SLOT_RC  = 3'd5;
    localparam logic [2:0] LAST_SLOT_EXT = 3'd1;

    // shared scaler operations
    typedef logic [2:0] t_scale_op;
    localparam t_scale_op SC_NOP  = 3'd0;
    localparam t_scale_op SC_MUL1 = 3'd1;
    localparam t_scale_op SC_ADD1 = 3'd2;
    localparam t_scale_op SC_MUL2 = 3'd3;
    localparam t_scale_op SC_ADD2 = 3'd4;

    typedef struct packed {
        logic signed [31:0] gain_first;
        logic signed [31:0] offset_first;
        logic signed [31:0] gain_second;
        logic signed [31:0] offset_second;
    } t_scale_cfg;

    // channel number held in a slot
    function automatic logic [2:0] chan_of_slot(input logic [2:0] slot);
        logic [2:0] ch;
        case (slot)
            3'd0:    ch = 3'd1;
            3'd1:    ch = 3'd2;
            3'd2:    ch = 3'd4;
            3'd3:    ch = 3'd5;
            3'd4:    ch = 3'd6;
            default: ch = 3'd7;
        endcase
        return ch;
    endfunction

    // first frame byte of an 11-bit channel
    function automatic logic [3:0] chan_byte_idx(input logic [2:0] ch);
        logic [6:0] bitpos;
        bitpos = 7'(ch) * 7'd11;
        return 4'(7'd1 + (bitpos >> 3));
    endfunction

    // bit offset of the channel inside its first byte
    function automatic logic [2:0] chan_shift(input logic [2:0] ch);
        logic [6:0] bitpos;
        bitpos = 7'(ch) * 7'd11;
        return bitpos[2:0];
    endfunction

endpackage

`default_nettype wire

FILE: sv/sfmd_if.sv
// ----------------------------------------------------------------------------
// sfmd_if
// Valid/ready channels: received bytes in, thrust results out.
// ----------------------------------------------------------------------------
`default_nettype none

interface sfmd_req_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       frame_end;

    modport source (output valid, rx_byte, frame_end, input ready);
    modport sink   (input valid, rx_byte, frame_end, output ready);
endinterface

interface sfmd_rsp_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] thrust_value;
    logic               thruster_side;
    logic               last_result;
    logic [5:0]         current_mode;

    modport source (output valid, thrust_value, thruster_side, last_result,
                    current_mode, input ready);
    modport sink   (input valid, thrust_value, thruster_side, last_result,
                    current_mode, output ready);
endinterface

`default_nettype wire

FILE: sv/sbus_frame_mode_decoder.sv
// ----------------------------------------------------------------------------
// sbus_frame_mode_decoder
// Collects a frame byte by byte, scales its channels and issues thrust
// commands and mode updates at the frame end.
// ----------------------------------------------------------------------------
//  channel   dir  request payload
//  i_req     in   rx_byte[7:0], frame_end
//  o_rsp     out  thrust_value[15:0], thruster_side, last_result, current_mode[5:0]
//  i_cfg_*   in   4 x 32-bit scaling registers, write only
//
//  A non-frame-end byte leaves the decoder idle. An evaluated frame end runs each
//  scaled channel through fetch, multiply, add, multiply, add and store in the
//  shared multiplier/adder (6 channels for header 0x0F, 2 for 0xFF), then a
//  decision, then any results, one per cycle while o_rsp is ready. i_req.ready is
//  low throughout. Sync active-low reset clears only control and cfg state.
// ----------------------------------------------------------------------------
`default_nettype none

module sbus_frame_mode_decoder #(
    parameter int FRAME_LEN = 25
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    sfmd_req_if.sink         i_req,
    sfmd_rsp_if.source       o_rsp,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_addr,
    input  wire logic [31:0] i_cfg_wdata
);

    import sfmd_pkg::*;

    localparam int CW = $clog2(FRAME_LEN + 1);
    localparam int AW = $clog2(FRAME_LEN);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_FETCH  = 4'd1;
    localparam logic [3:0] S_MUL1   = 4'd2;
    localparam logic [3:0] S_ADD1   = 4'd3;
    localparam logic [3:0] S_MUL2   = 4'd4;
    localparam logic [3:0] S_ADD2   = 4'd5;
    localparam logic [3:0] S_STORE  = 4'd6;
    localparam logic [3:0] S_DECIDE = 4'd7;
    localparam logic [3:0] S_OUT_L  = 4'd8;
    localparam logic [3:0] S_OUT_R  = 4'd9;

    logic [3:0]         r_state, n_state;
    logic [CW-1:0]      r_count, n_count;
    logic [5:0]         r_mode, n_mode;
    logic               r_flag, n_flag;
    logic [2:0]         r_slot, n_slot;
    logic [1:0]         r_step, n_step;
    logic [7:0]         r_hdr;
    logic [7:0]         r_byte [3];
    logic signed [15:0] r_chval [NUM_SLOTS];
    logic signed [15:0] r_left, r_right;
    t_scale_cfg         r_cfg;

    logic               req_fire, rsp_fire;
    logic               frame_ok;
    logic               mem_we;
    logic [AW-1:0]      mem_raddr;
    logic [7:0]         mem_rdata;
    logic [2:0]         chan;
    logic [23:0]        win;
    logic [10:0]        raw;
    t_scale_op          sc_op;
    logic signed [15:0] sc_value;
    logic [2:0]         last_slot;
    logic               emit;
    logic signed [15:0] left_val, right_val;

    assign req_fire    = i_req.valid && i_req.ready;
    assign rsp_fire    = o_rsp.valid && o_rsp.ready;
    assign i_req.ready = (r_state == S_IDLE);

    // byte store
    assign mem_we = req_fire && (r_count < CW'(FRAME_LEN));

    sfmd_frame_mem #(
        .DEPTH (FRAME_LEN)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (i_req.rx_byte),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // channel fetch address and bit extraction
    assign chan      = chan_of_slot(r_slot);
    assign mem_raddr = AW'(chan_byte_idx(chan)) + AW'(r_step);
    assign win       = {r_byte[2], r_byte[1], r_byte[0]};
    assign raw       = 11'(win >> chan_shift(chan));
    assign last_slot = (r_hdr == HDR_RC) ? LAST_SLOT_RC : LAST_SLOT_EXT;

    // scaler operation follows the sequencer state
    always_comb begin
        case (r_state)
            S_MUL1:  sc_op = SC_MUL1;
            S_ADD1:  sc_op = SC_ADD1;
            S_MUL2:  sc_op = SC_MUL2;
            S_ADD2:  sc_op = SC_ADD2;
            default: sc_op = SC_NOP;
        endcase
    end

    sfmd_scaler u_scaler (
        .i_clk   (i_clk),
        .i_op    (sc_op),
        .i_raw   (raw),
        .i_cfg   (r_cfg),
        .o_value (sc_value)
    );

    // frame end with the right length and a header that does something
    assign frame_ok = (r_count == CW'(FRAME_LEN - 1)) &&
                      ((r_hdr == HDR_RC) ||
                       ((r_hdr == HDR_EXT) && (r_mode == MODE_DRIVE) && r_flag));

    // thrust decision and mode update
    always_comb begin
        emit      = 1'b1;
        left_val  = (r_chval[0] == THRUST_MIN) ? THRUST_MAX : -r_chval[0];
        right_val = r_chval[1];
        n_mode    = r_mode;
        n_flag    = r_flag;
        if (r_hdr == HDR_RC) begin
            if ((r_mode == MODE_DRIVE) && !r_flag) begin
                emit = 1'b1;
            end else if (r_mode == MODE_ZERO) begin
                left_val  = CMD_ZERO;
                right_val = CMD_ZERO;
            end else if (r_mode == MODE_FIXED) begin
                left_val  = THRUST_FIXED;
                right_val = THRUST_FIXED;
            end else begin
                emit = 1'b0;
            end
            if ((r_chval[2] == CMD_HI) && !r_flag) begin
                n_mode = MODE_THREE;
            end else if ((r_chval[3] == CMD_HI) && !r_flag) begin
                n_mode = MODE_DRIVE;
            end else if ((r_chval[4] == CMD_HI) && !r_flag) begin
                n_mode = MODE_HIGH;
            end else if ((r_chval[4] == CMD_LO) && !r_flag) begin
                n_mode = MODE_FIXED;
            end else if (r_chval[5] == CMD_HI) begin
                n_mode = MODE_FIVE;
            end else if (r_chval[5] == CMD_LO) begin
                n_flag = 1'b1;
            end else if (r_chval[5] == CMD_ZERO) begin
                n_flag = 1'b0;
                n_mode = MODE_ZERO;
            end
        end
    end

    // sequencer next state
    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_slot  = r_slot;
        n_step  = r_step;
        case (r_state)
            S_IDLE: begin
                if (req_fire) begin
                    if (i_req.frame_end) begin
                        n_count = '0;
                        n_slot  = '0;
                        n_step  = '0;
                        if (frame_ok) begin
                            n_state = S_FETCH;
                        end
                    end else if (r_count < CW'(FRAME_LEN)) begin
                        n_count = r_count + 1'b1;
                    end
                end
            end
            S_FETCH: begin
                n_step = r_step + 1'b1;
                if (r_step == 2'd3) begin
                    n_state = S_MUL1;
                end
            end
            S_MUL1:  n_state = S_ADD1;
            S_ADD1:  n_state = S_MUL2;
            S_MUL2:  n_state = S_ADD2;
            S_ADD2:  n_state = S_STORE;
            S_STORE: begin
                n_step = '0;
                if (r_slot == last_slot) begin
                    n_state = S_DECIDE;
                end else begin
                    n_slot  = r_slot + 1'b1;
                    n_state = S_FETCH;
                end
            end
            S_DECIDE: n_state = emit ? S_OUT_L : S_IDLE;
            S_OUT_L:  if (rsp_fire) n_state = S_OUT_R;
            S_OUT_R:  if (rsp_fire) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_mode  <= MODE_ZERO;
            r_flag  <= 1'b0;
            r_slot  <= '0;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_slot  <= n_slot;
            r_step  <= n_step;
            if ((r_state == S_DECIDE) && (r_hdr == HDR_RC)) begin
                r_mode <= n_mode;
                r_flag <= n_flag;
            end
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gain_first    <= GAIN_RESET;
            r_cfg.offset_first  <= OFFSET_RESET;
            r_cfg.gain_second   <= GAIN_RESET;
            r_cfg.offset_second <= OFFSET_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_GAIN_FIRST:    r_cfg.gain_first    <= i_cfg_wdata;
                CFG_OFFSET_FIRST:  r_cfg.offset_first  <= i_cfg_wdata;
                CFG_GAIN_SECOND:   r_cfg.gain_second   <= i_cfg_wdata;
                CFG_OFFSET_SECOND: r_cfg.offset_second <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // payload registers: header, fetched bytes, channel values, results
    always_ff @(posedge i_clk) begin
        if (req_fire && (r_count == '0)) begin
            r_hdr <= i_req.rx_byte;
        end
        if ((r_state == S_FETCH) && (r_step != 2'd0)) begin
            r_byte[r_step - 2'd1] <= mem_rdata;
        end
        if (r_state == S_STORE) begin
            r_chval[r_slot] <= sc_value;
        end
        if (r_state == S_DECIDE) begin
            r_left  <= left_val;
            r_right <= right_val;
        end
    end

    // result channel
    assign o_rsp.valid         = (r_state == S_OUT_L) || (r_state == S_OUT_R);
    assign o_rsp.thrust_value  = (r_state == S_OUT_R) ? r_right : r_left;
    assign o_rsp.thruster_side = (r_state == S_OUT_R);
    assign o_rsp.last_result   = (r_state == S_OUT_R);
    assign o_rsp.current_mode  = r_mode;

    // a taken left result is followed straight away by the right one
    a_pair_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (rsp_fire && !o_rsp.last_result) |=>
            (o_rsp.valid && o_rsp.last_result && o_rsp.thruster_side))
        else $error("right result did not follow left result");

    // no byte is taken while a result is pending
    a_no_req_on_rsp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> !i_req.ready)
        else $error("byte accepted while result pending");

    // byte count never passes the frame length
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(FRAME_LEN))
        else $error("byte count beyond frame length");

    // mode changes only out of the decision step
    a_mode_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_DECIDE) |=> $stable(r_mode))
        else $error("mode changed outside decision");

endmodule

`default_nettype wire

FILE: sv/sfmd_frame_mem.sv
// ----------------------------------------------------------------------------
// sfmd_frame_mem
// Frame byte store, one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module sfmd_frame_mem #(
    parameter int DEPTH = 25
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [7:0]               i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [7:0]               o_rdata
);

    logic [7:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

FILE: sv/sfmd_scaler.sv
// ----------------------------------------------------------------------------
// sfmd_scaler
// Shared multiply / add-saturate unit for the two Q16.16 scaling passes.
// ----------------------------------------------------------------------------
`default_nettype none

module sfmd_scaler (
    input  wire logic                  i_clk,
    input  wire sfmd_pkg::t_scale_op   i_op,
    input  wire logic [10:0]           i_raw,
    input  wire sfmd_pkg::t_scale_cfg  i_cfg,
    output logic signed [15:0]         o_value
);

    import sfmd_pkg::*;

    logic signed [63:0] r_prod;
    logic signed [31:0] r_acc;

    logic signed [32:0] mul_a;
    logic signed [31:0] mul_b;
    logic signed [64:0] mul_p;
    logic signed [63:0] add_a;
    logic signed [31:0] add_b;
    logic               add_rnd;
    logic signed [63:0] sum;
    logic signed [31:0] sum_sat;

    // multiplier operands: raw channel by first gain, or first result by second gain
    always_comb begin
        if (i_op == SC_MUL1) begin
            mul_a = {22'b0, i_raw};
            mul_b = i_cfg.gain_first;
        end else begin
            mul_a = {r_acc[31], r_acc};
            mul_b = i_cfg.gain_second;
        end
        mul_p = mul_a * mul_b;
    end

    // adder: offset add, with shift and round toward zero on the second pass
    always_comb begin
        if (i_op == SC_ADD1) begin
            add_a   = r_prod;
            add_b   = i_cfg.offset_first;
            add_rnd = 1'b0;
        end else begin
            add_a   = r_prod >>> 16;
            add_b   = i_cfg.offset_second;
            add_rnd = r_prod[63] && (r_prod[15:0] != 16'd0);
        end
        sum = add_a + {{32{add_b[31]}}, add_b} + 64'(add_rnd);
        if (sum[63:31] != {33{sum[31]}}) begin
            sum_sat = sum[63] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else begin
            sum_sat = sum[31:0];
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        case (i_op)
            SC_MUL1, SC_MUL2: r_prod <= mul_p[63:0];
            SC_ADD1, SC_ADD2: r_acc  <= sum_sat;
            default: ;
        endcase
    end

    // integer part, truncated toward zero
    assign o_value = r_acc[31:16] + 16'(r_acc[31] && (r_acc[15:0] != 16'd0));

endmodule

`default_nettype wire
